// ===== rtl/idec_pkg.sv =====
// ----------------------------------------------------------------------------
// idec_pkg
// Shared types and constants of the integrating debouncer and edge counter.
// ----------------------------------------------------------------------------
`default_nettype none

package idec_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int EDGE_W      = 2;
    localparam int COUNT_OUT_W = 32;

    localparam logic [CFG_DATA_W-1:0] LIMIT_AT_RESET = 16'd100;
    localparam logic [CFG_DATA_W-1:0] LIMIT_MIN      = 16'd1;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_LIMIT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_POLARITY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RISE_IRQ_ENABLE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FALL_IRQ_ENABLE = 2'd3;

    localparam logic [EDGE_W-1:0] EDGE_NONE = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_RISE = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_FALL = 2'd2;

    typedef struct packed {
        logic invert_polarity;
        logic rise_irq_enable;
        logic fall_irq_enable;
    } cfg_flags_t;

    typedef struct packed {
        logic mode;
        logic pin_level;
        logic clear_irq;
        logic clear_rise_count;
        logic clear_fall_count;
    } item_t;

    typedef struct packed {
        logic                   level;
        logic [EDGE_W-1:0]      edge_event;
        logic [COUNT_OUT_W-1:0] rise_count;
        logic [COUNT_OUT_W-1:0] fall_count;
        logic                   irq_pending;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/idec_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// idec_cfg_regs
// Configuration registers; the debounce limit is forced into its legal range.
// ----------------------------------------------------------------------------
`default_nettype none

module idec_cfg_regs #(
    parameter int IntegratorWidth = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [idec_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [idec_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [((IntegratorWidth < 16) ? IntegratorWidth : 16)-1:0] limit,
    output logic [((IntegratorWidth < 16) ? IntegratorWidth : 16)-1:0] limit_new,
    output logic                                    limit_wr,
    output idec_pkg::cfg_flags_t                    flags
);

    localparam int LimW = (IntegratorWidth < 16) ? IntegratorWidth : 16;
    localparam logic [idec_pkg::CFG_DATA_W-1:0] LimMax =
        idec_pkg::CFG_DATA_W'((32'd1 << LimW) - 32'd1);
    localparam logic [idec_pkg::CFG_DATA_W-1:0] LimReset =
        (idec_pkg::LIMIT_AT_RESET > LimMax) ? LimMax : idec_pkg::LIMIT_AT_RESET;

    logic [LimW-1:0]            limit_reg;
    logic [LimW-1:0]            limit_next;
    idec_pkg::cfg_flags_t       flags_reg;
    idec_pkg::cfg_flags_t       flags_next;
    logic [idec_pkg::CFG_DATA_W-1:0] legal;

    always_comb
    begin
        legal = cfg_data;
        if (legal > LimMax)
        begin
            legal = LimMax;
        end
        if (legal == '0)
        begin
            legal = idec_pkg::LIMIT_MIN;
        end
    end

    always_comb
    begin
        limit_next = limit_reg;
        flags_next = flags_reg;
        limit_wr   = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                idec_pkg::REG_DEBOUNCE_LIMIT:
                begin
                    limit_next = LimW'(legal);
                    limit_wr   = 1'b1;
                end
                idec_pkg::REG_INVERT_POLARITY: flags_next.invert_polarity = cfg_data[0];
                idec_pkg::REG_RISE_IRQ_ENABLE: flags_next.rise_irq_enable = cfg_data[0];
                idec_pkg::REG_FALL_IRQ_ENABLE: flags_next.fall_irq_enable = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LimW'(LimReset);
            flags_reg <= '0;
        end
        else
        begin
            limit_reg <= limit_next;
            flags_reg <= flags_next;
        end
    end

    assign limit     = limit_reg;
    assign limit_new = limit_next;
    assign flags     = flags_reg;

endmodule

`default_nettype wire

// ===== rtl/idec_core.sv =====
// ----------------------------------------------------------------------------
// idec_core
// Debounce state: integrator, level, edge counters and sticky interrupt.
// ----------------------------------------------------------------------------
`default_nettype none

module idec_core #(
    parameter int IntegratorWidth = 16,
    parameter int CounterWidth    = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_fire,
    input  wire idec_pkg::item_t        item,
    input  wire logic [((IntegratorWidth < 16) ? IntegratorWidth : 16)-1:0] limit,
    input  wire logic [((IntegratorWidth < 16) ? IntegratorWidth : 16)-1:0] limit_new,
    input  wire logic                   limit_wr,
    input  wire idec_pkg::cfg_flags_t   flags,
    output idec_pkg::result_t           result
);

    logic [IntegratorWidth-1:0] integ_reg;
    logic [IntegratorWidth-1:0] integ_next;
    logic                       level_reg;
    logic                       level_next;
    logic [CounterWidth-1:0]    rise_reg;
    logic [CounterWidth-1:0]    rise_next;
    logic [CounterWidth-1:0]    fall_reg;
    logic [CounterWidth-1:0]    fall_next;
    logic                       irq_reg;
    logic                       irq_next;

    logic [IntegratorWidth-1:0] lim_ext;
    logic [IntegratorWidth-1:0] lim_new_ext;
    logic                       logical;
    logic [IntegratorWidth-1:0] integ_t;
    logic                       level_t;
    logic [idec_pkg::EDGE_W-1:0] edge_t;
    logic [CounterWidth-1:0]    rise_t;
    logic [CounterWidth-1:0]    fall_t;
    logic                       irq_t;

    assign lim_ext     = IntegratorWidth'(limit);
    assign lim_new_ext = IntegratorWidth'(limit_new);
    assign logical     = item.pin_level ^ flags.invert_polarity;

    always_comb
    begin
        integ_t = integ_reg;
        level_t = level_reg;
        edge_t  = idec_pkg::EDGE_NONE;
        if (item.mode)
        begin
            level_t = logical;
            integ_t = logical ? lim_ext : '0;
        end
        else
        begin
            if (logical)
            begin
                if (integ_reg < lim_ext)
                begin
                    integ_t = integ_reg + IntegratorWidth'(1);
                end
            end
            else if (integ_reg != '0)
            begin
                integ_t = integ_reg - IntegratorWidth'(1);
            end
            if (integ_t >= lim_ext)
            begin
                if (!level_reg)
                begin
                    level_t = 1'b1;
                    edge_t  = idec_pkg::EDGE_RISE;
                end
            end
            else if (integ_t == '0)
            begin
                if (level_reg)
                begin
                    level_t = 1'b0;
                    edge_t  = idec_pkg::EDGE_FALL;
                end
            end
        end
    end

    always_comb
    begin
        rise_t = rise_reg;
        fall_t = fall_reg;
        irq_t  = irq_reg;
        if (edge_t == idec_pkg::EDGE_RISE)
        begin
            rise_t = rise_reg + CounterWidth'(1);
            irq_t  = irq_reg | flags.rise_irq_enable;
        end
        if (edge_t == idec_pkg::EDGE_FALL)
        begin
            fall_t = fall_reg + CounterWidth'(1);
            irq_t  = irq_reg | flags.fall_irq_enable;
        end
    end

    always_comb
    begin
        result.level       = level_t;
        result.edge_event  = edge_t;
        result.rise_count  = idec_pkg::COUNT_OUT_W'(rise_t);
        result.fall_count  = idec_pkg::COUNT_OUT_W'(fall_t);
        result.irq_pending = irq_t;
    end

    always_comb
    begin
        integ_next = integ_reg;
        level_next = level_reg;
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        irq_next   = irq_reg;
        if (limit_wr)
        begin
            if (integ_reg > lim_new_ext)
            begin
                integ_next = lim_new_ext;
            end
        end
        else if (item_fire)
        begin
            integ_next = integ_t;
            level_next = level_t;
            rise_next  = item.clear_rise_count ? '0 : rise_t;
            fall_next  = item.clear_fall_count ? '0 : fall_t;
            irq_next   = item.clear_irq ? 1'b0 : irq_t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            level_reg <= 1'b0;
            rise_reg  <= '0;
            fall_reg  <= '0;
            irq_reg   <= 1'b0;
        end
        else
        begin
            integ_reg <= integ_next;
            level_reg <= level_next;
            rise_reg  <= rise_next;
            fall_reg  <= fall_next;
            irq_reg   <= irq_next;
        end
    end

    // integrator stays within the limit
    a_integ_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        integ_reg <= lim_ext)
        else $error("integrator above debounce limit");

    // a high level always has a nonzero integrator
    a_level_integ: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg |-> (integ_reg != '0))
        else $error("level high with empty integrator");

    // a level change on a normal tick is reported as an edge
    a_change_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && !limit_wr && !item.mode && (level_t != level_reg))
        |-> (edge_t != idec_pkg::EDGE_NONE))
        else $error("level change without edge");

    // a counter clear takes effect after the word
    a_rise_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && !limit_wr && item.clear_rise_count) |=> (rise_reg == '0))
        else $error("rising counter not cleared");

endmodule

`default_nettype wire

// ===== rtl/integrating_debouncer_edge_counter_unit.sv =====
// ----------------------------------------------------------------------------
// integrating_debouncer_edge_counter_unit
// Integrating pin debouncer with rising and falling edge counters.
//
// Each input word is one sample tick of a raw pin plus clear requests; each
// word gives exactly one result word: debounced level, edge of this tick,
// both edge counts and the interrupt flag before the clears are applied.
// Input channel in_valid / in_stall, output channel out_valid / out_stall.
// A word is taken at an edge with valid high and stall low.
// An input word passes through the input register, then the state update and
// the result register load in the same cycle; while out_stall holds the
// result register, the word waits in the input register.
// Throughput is one word per cycle while out_stall is low; the state update
// is a combinational compare and step on the integrator and counters.
// When out_stall is held the result register keeps its word, the input
// register holds one more and in_stall rises until the result is taken.
// Reset clears the state, the counters and the flag; the limit is 100, or the integrator maximum if smaller.
// Configuration writes on cfg_we / cfg_index / cfg_data are taken at once,
// and are expected only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module integrating_debouncer_edge_counter_unit #(
    parameter int INTEGRATOR_WIDTH = 16,
    parameter int COUNTER_WIDTH    = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [idec_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [idec_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               mode,
    input  wire logic                               pin_level,
    input  wire logic                               clear_irq,
    input  wire logic                               clear_rise_count,
    input  wire logic                               clear_fall_count,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    level,
    output logic [idec_pkg::EDGE_W-1:0]             edge_event,
    output logic [idec_pkg::COUNT_OUT_W-1:0]        rise_count,
    output logic [idec_pkg::COUNT_OUT_W-1:0]        fall_count,
    output logic                                    irq_pending
);

    localparam int LimW = (INTEGRATOR_WIDTH < 16) ? INTEGRATOR_WIDTH : 16;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    idec_pkg::item_t        item_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    idec_pkg::result_t      result_reg;
    idec_pkg::result_t      result;

    logic [LimW-1:0]        limit;
    logic [LimW-1:0]        limit_new;
    logic                   limit_wr;
    idec_pkg::cfg_flags_t   flags;
    logic                   accept;
    logic                   fire;

    idec_cfg_regs #(
        .IntegratorWidth(INTEGRATOR_WIDTH)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .limit    (limit),
        .limit_new(limit_new),
        .limit_wr (limit_wr),
        .flags    (flags)
    );

    idec_core #(
        .IntegratorWidth(INTEGRATOR_WIDTH),
        .CounterWidth   (COUNTER_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_fire(fire),
        .item     (item_reg),
        .limit    (limit),
        .limit_new(limit_new),
        .limit_wr (limit_wr),
        .flags    (flags),
        .result   (result)
    );

    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.mode             <= mode;
            item_reg.pin_level        <= pin_level;
            item_reg.clear_irq        <= clear_irq;
            item_reg.clear_rise_count <= clear_rise_count;
            item_reg.clear_fall_count <= clear_fall_count;
        end
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign level       = result_reg.level;
    assign edge_event  = result_reg.edge_event;
    assign rise_count  = result_reg.rise_count;
    assign fall_count  = result_reg.fall_count;
    assign irq_pending = result_reg.irq_pending;

    // a held input word moves on as soon as the result register frees up
    a_no_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input word not moved to result register");

    // a stalled result word keeps its valid
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(result_reg)))
        else $error("stalled result word lost");

    // input stall only while both registers are full
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with free space");

endmodule

`default_nettype wire
